/* hdl/sfcc_pkg.sv */
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared codes and constants for the sensor frame CRC checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    // Frame lengths in data bytes, CRC byte not counted
    localparam int SCRATCH_BYTES = 8;
    localparam int IDENT_BYTES   = 7;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Bus event selector
    localparam logic [1:0] CMD_NO_PRESENCE = 2'd0;
    localparam logic [1:0] CMD_SCRATCH     = 2'd1;
    localparam logic [1:0] CMD_IDENT       = 2'd2;

    // Result status
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_NO_DEV = 2'd2
    } status_t;

    // Frame kind
    localparam logic KIND_SCRATCH = 1'b0;
    localparam logic KIND_IDENT   = 1'b1;

endpackage

/* hdl/sfcc_if.sv */
// ----------------------------------------------------------------------------
// sfcc_byte_if / sfcc_result_if
// Valid/ready channels for received bus bytes and for frame results.
// ----------------------------------------------------------------------------
interface sfcc_byte_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output cmd, output data_byte, output first_byte,
                    input ready);
    modport sink   (input valid, input cmd, input data_byte, input first_byte,
                    output ready);
endinterface

interface sfcc_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               frame_kind;
    logic               present;
    logic signed [15:0] raw_temperature;
    logic signed [15:0] previous_raw_temperature;
    logic [7:0]         sensor_setting_byte;
    logic [7:0]         family_id;
    logic [47:0]        serial_id;
    logic [7:0]         crc_err_count;

    modport source (output valid, output status, output frame_kind, output present,
                    output raw_temperature, output previous_raw_temperature,
                    output sensor_setting_byte, output family_id,
                    output serial_id, output crc_err_count, input ready);
    modport sink   (input valid, input status, input frame_kind, input present,
                    input raw_temperature, input previous_raw_temperature,
                    input sensor_setting_byte, input family_id,
                    input serial_id, input crc_err_count, output ready);
endinterface

/* hdl/sfcc_crc8_step.sv */
// ----------------------------------------------------------------------------
// sfcc_crc8_step
// One-byte update of the reflected CRC-8, fully combinational.
// ----------------------------------------------------------------------------
module sfcc_crc8_step import sfcc_pkg::*;
(
    input  logic [7:0] crc,
    input  logic [7:0] data,
    output logic [7:0] crc_out
);

    // Shift eight bits out, LSB first
    always_comb
    begin
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

/* hdl/sensor_frame_crc_checker_top.sv */
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker_top
// Checks scratchpad and identity frames from a one-wire sensor bus.
// ----------------------------------------------------------------------------
// Accepts one bus byte per cycle unless a byte waits in the input register: the
// byte is captured in an input register, then the frame state and CRC-8 are
// updated and any result is loaded into the output register. The byte-wide
// CRC update, combinational and fed back into the running CRC register, sets the rate.
// Only the CRC byte of a frame or a missing presence pulse produces a result;
// a byte waits in the input register only while a result is pending and the
// output side is stalled.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker_top import sfcc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sfcc_byte_if.sink     bytes,
    sfcc_result_if.source results
);

    localparam logic [3:0] SCRATCH_LEN = 4'(SCRATCH_BYTES);
    localparam logic [3:0] IDENT_LEN   = 4'(IDENT_BYTES);

    // Input register
    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_data_reg;
    logic       s1_first_reg;

    // Frame state
    logic [3:0]         idx_reg, idx_next;
    logic [7:0]         crc_reg, crc_next;
    logic               active_reg, active_next;
    logic               kind_reg, kind_next;
    logic               present_reg, present_next;
    logic signed [15:0] raw_reg, raw_next;
    logic signed [15:0] prev_reg, prev_next;
    logic [7:0]         setting_reg, setting_next;
    logic [7:0]         family_reg, family_next;
    logic [47:0]        serial_reg, serial_next;
    logic [7:0]         fail_reg, fail_next;
    logic [7:0]         buf_reg [8];

    // Output register
    logic       out_valid_reg;
    status_t    out_status_reg;
    logic       out_kind_reg;

    // Step control
    logic       produce;
    logic       buf_we;
    status_t    status_next;
    logic       kind_result;
    logic       out_free;
    logic       step;
    logic       load;
    logic       eff_kind;
    logic [3:0] eff_idx;
    logic [7:0] eff_crc;
    logic [3:0] frame_len;
    logic [7:0] crc_upd;

    sfcc_crc8_step u_crc
    (
        .crc     (eff_crc),
        .data    (s1_data_reg),
        .crc_out (crc_upd)
    );

    assign out_free    = !out_valid_reg || results.ready;
    assign step        = s1_valid_reg && (!produce || out_free);
    assign load        = step && produce;
    assign bytes.ready = !s1_valid_reg || step;

    // Capture the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (bytes.ready)
            s1_valid_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_cmd_reg   <= bytes.cmd;
            s1_data_reg  <= bytes.data_byte;
            s1_first_reg <= bytes.first_byte;
        end
    end

    // Frame position as seen by this byte
    assign eff_kind  = s1_first_reg ? (s1_cmd_reg == CMD_IDENT) : kind_reg;
    assign eff_idx   = s1_first_reg ? 4'd0 : idx_reg;
    assign eff_crc   = s1_first_reg ? 8'd0 : crc_reg;
    assign frame_len = eff_kind ? IDENT_LEN : SCRATCH_LEN;

    // Next frame state and result
    always_comb
    begin
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        active_next  = active_reg;
        kind_next    = kind_reg;
        present_next = present_reg;
        raw_next     = raw_reg;
        prev_next    = prev_reg;
        setting_next = setting_reg;
        family_next  = family_reg;
        serial_next  = serial_reg;
        fail_next    = fail_reg;
        produce      = 1'b0;
        buf_we       = 1'b0;
        status_next  = STATUS_OK;
        kind_result  = KIND_SCRATCH;

        unique case (s1_cmd_reg) inside
            CMD_NO_PRESENCE:
            begin
                present_next = 1'b0;
                active_next  = 1'b0;
                idx_next     = 4'd0;
                crc_next     = 8'd0;
                produce      = 1'b1;
                status_next  = STATUS_NO_DEV;
            end
            CMD_SCRATCH, CMD_IDENT:
            begin
                if (s1_first_reg || active_reg)
                begin
                    active_next = 1'b1;
                    kind_next   = eff_kind;
                    if (eff_idx < frame_len)
                    begin
                        buf_we   = !eff_idx[3];
                        crc_next = crc_upd;
                        idx_next = 4'(eff_idx + 4'd1);
                    end
                    else
                    begin
                        // CRC byte closes the frame
                        active_next  = 1'b0;
                        idx_next     = 4'd0;
                        crc_next     = 8'd0;
                        present_next = 1'b1;
                        produce      = 1'b1;
                        kind_result  = eff_kind;
                        if (eff_crc == s1_data_reg)
                        begin
                            status_next = STATUS_OK;
                            if (eff_kind == KIND_IDENT)
                            begin
                                family_next = buf_reg[0];
                                serial_next = {buf_reg[6], buf_reg[5], buf_reg[4],
                                               buf_reg[3], buf_reg[2], buf_reg[1]};
                            end
                            else
                            begin
                                prev_next    = raw_reg;
                                raw_next     = $signed({buf_reg[1], buf_reg[0]});
                                setting_next = buf_reg[4];
                            end
                        end
                        else
                        begin
                            status_next = STATUS_CRC_ERR;
                            fail_next   = 8'(fail_reg + 8'd1);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Advance frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= 4'd0;
            crc_reg     <= 8'd0;
            active_reg  <= 1'b0;
            kind_reg    <= KIND_SCRATCH;
            present_reg <= 1'b0;
            raw_reg     <= 16'sd0;
            prev_reg    <= 16'sd0;
            setting_reg <= 8'd0;
            family_reg  <= 8'd0;
            serial_reg  <= 48'd0;
            fail_reg    <= 8'd0;
        end
        else if (step)
        begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            active_reg  <= active_next;
            kind_reg    <= kind_next;
            present_reg <= present_next;
            raw_reg     <= raw_next;
            prev_reg    <= prev_next;
            setting_reg <= setting_next;
            family_reg  <= family_next;
            serial_reg  <= serial_next;
            fail_reg    <= fail_next;
        end
    end

    // Store data bytes of the frame
    always_ff @(posedge clk)
    begin
        if (step && buf_we)
            buf_reg[eff_idx[2:0]] <= s1_data_reg;
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= load || (out_valid_reg && !results.ready);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= status_next;
            out_kind_reg   <= kind_result;
        end
    end

    // Committed values are stable while a result is pending
    assign results.valid                    = out_valid_reg;
    assign results.status                   = out_status_reg;
    assign results.frame_kind               = out_kind_reg;
    assign results.present                  = present_reg;
    assign results.raw_temperature          = raw_reg;
    assign results.previous_raw_temperature = prev_reg;
    assign results.sensor_setting_byte      = setting_reg;
    assign results.family_id                = family_reg;
    assign results.serial_id                = serial_reg;
    assign results.crc_err_count            = fail_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !step || !produce)
        else $error("pending result overwritten");

    // A CRC mismatch bumps the failure count
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && status_next == STATUS_CRC_ERR) |=> fail_reg == 8'($past(fail_reg) + 8'd1))
        else $error("failure count not advanced on mismatch");

    // No-device result clears the present flag
    a_no_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (load && status_next == STATUS_NO_DEV) |=> !present_reg)
        else $error("present flag set after no-device event");

    // Byte index stays within the longest frame
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= SCRATCH_LEN || idx_reg <= IDENT_LEN)
        else $error("byte index out of range");

endmodule
